### rtl/isotp_pkg.sv
// Shared types and codes for the ISO-TP receive frame classifier.
// Used by isotp_cfg_regs, isotp_decode and isotp_rx_frame_classifier; depends on nothing.
package isotp_pkg;

  localparam int IdW = 29;

  // Link status codes (3 bits, code 7 has no name and passes through)
  localparam logic [2:0] LS_IDLE    = 3'd0;
  localparam logic [2:0] LS_SEND_SF = 3'd1;
  localparam logic [2:0] LS_SEND_FF = 3'd2;
  localparam logic [2:0] LS_WAIT_FC = 3'd3;
  localparam logic [2:0] LS_SEND_CF = 3'd4;
  localparam logic [2:0] LS_SEND_FC = 3'd5;
  localparam logic [2:0] LS_WAIT_CF = 3'd6;

  // PCI frame types (upper nibble of data byte 0)
  localparam logic [3:0] PCI_SF = 4'd0;
  localparam logic [3:0] PCI_FF = 4'd1;
  localparam logic [3:0] PCI_CF = 4'd2;
  localparam logic [3:0] PCI_FC = 4'd3;

  localparam logic [3:0] MinDlc = 4'd8;

  // Verdict codes
  localparam logic [1:0] VERDICT_HANDLED  = 2'd0;
  localparam logic [1:0] VERDICT_SHORT    = 2'd1;
  localparam logic [1:0] VERDICT_MISMATCH = 2'd2;
  localparam logic [1:0] VERDICT_BUSY     = 2'd3;

  // Frame kind codes
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_SINGLE = 3'd1;
  localparam logic [2:0] KIND_FIRST  = 3'd2;
  localparam logic [2:0] KIND_CONSEC = 3'd3;
  localparam logic [2:0] KIND_FLOW   = 3'd4;

  // One received frame header plus link context
  typedef struct packed {
    logic [IdW-1:0] can_id;
    logic [3:0]     frame_dlc;
    logic [7:0]     pci_byte;
    logic [7:0]     second_byte;
    logic [7:0]     third_byte;
    logic [2:0]     link_status;
    logic           module_on;
  } frame_t;

  // One classification result
  typedef struct packed {
    logic [1:0]  verdict;
    logic        functional_addr;
    logic [2:0]  frame_kind;
    logic [3:0]  single_length;
    logic [11:0] first_length;
    logic [3:0]  sequence_number;
    logic [3:0]  flow_status;
    logic [7:0]  block_size;
    logic [7:0]  st_min;
    logic [2:0]  next_link_status;
    logic        wake_request;
  } result_t;

endpackage

### rtl/isotp_cfg_regs.sv
// APB-style register file holding the functional and physical receive IDs.
// Depends on isotp_pkg for the identifier width.
module isotp_cfg_regs (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output logic [isotp_pkg::IdW-1:0] functional_rx_id,
  output logic [isotp_pkg::IdW-1:0] physical_rx_id
);
  import isotp_pkg::*;

  localparam logic REG_FUNC = 1'b0;

  logic [IdW-1:0] func_id_r;
  logic [IdW-1:0] phys_id_r;
  logic           wr_en;
  logic           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_id_r <= '0;
      phys_id_r <= '0;
    end else if (wr_en) begin
      if (reg_sel == REG_FUNC) begin
        func_id_r <= pwdata[IdW-1:0];
      end else begin
        phys_id_r <= pwdata[IdW-1:0];
      end
    end
  end

  // Read-back
  always_comb begin
    prdata = '0;
    if (reg_sel == REG_FUNC) begin
      prdata[IdW-1:0] = func_id_r;
    end else begin
      prdata[IdW-1:0] = phys_id_r;
    end
  end

  assign functional_rx_id = func_id_r;
  assign physical_rx_id   = phys_id_r;

endmodule

### rtl/isotp_decode.sv
// Combinational classification of one registered frame header.
// Depends on isotp_pkg for frame_t, result_t and the protocol codes.
module isotp_decode (
  input  isotp_pkg::frame_t         frame,
  input  logic [isotp_pkg::IdW-1:0] functional_rx_id,
  input  logic [isotp_pkg::IdW-1:0] physical_rx_id,
  output isotp_pkg::result_t        result
);
  import isotp_pkg::*;

  logic [3:0] pci_type;
  logic [3:0] pci_low;
  logic       func_match;
  logic       phys_match;
  logic [2:0] st;
  logic       tx_busy;

  assign pci_type   = frame.pci_byte[7:4];
  assign pci_low    = frame.pci_byte[3:0];
  assign func_match = (frame.can_id == functional_rx_id);
  assign phys_match = (frame.can_id == physical_rx_id);
  assign st         = frame.link_status;
  assign tx_busy    = (st == LS_WAIT_FC) || (st == LS_SEND_CF);

  always_comb begin
    result = '0;
    result.next_link_status = st;
    if (frame.frame_dlc < MinDlc) begin
      result.verdict = VERDICT_SHORT;
    end else if (!func_match && !phys_match) begin
      result.verdict = VERDICT_MISMATCH;
    end else begin
      // functional match wins when both IDs are equal
      result.functional_addr = func_match;
      if (tx_busy && (pci_type != PCI_FC)) begin
        result.verdict = VERDICT_BUSY;
      end else begin
        result.verdict      = VERDICT_HANDLED;
        result.wake_request = ~frame.module_on;
        case (pci_type)
          PCI_SF: begin
            // a single frame aborts a wait for consecutive frames
            if (st == LS_WAIT_CF || st == LS_IDLE) begin
              result.next_link_status = LS_IDLE;
              result.frame_kind       = KIND_SINGLE;
              result.single_length    = pci_low;
            end
          end
          PCI_FF: begin
            if (!func_match && st != LS_SEND_FC && st != LS_SEND_CF) begin
              result.frame_kind   = KIND_FIRST;
              result.first_length = {pci_low, frame.second_byte};
            end
          end
          PCI_CF: begin
            if (!func_match && st == LS_WAIT_CF) begin
              result.frame_kind      = KIND_CONSEC;
              result.sequence_number = pci_low;
            end
          end
          PCI_FC: begin
            if (!func_match && tx_busy) begin
              result.frame_kind  = KIND_FLOW;
              result.flow_status = pci_low;
              result.block_size  = frame.second_byte;
              result.st_min      = frame.third_byte;
            end
          end
          default: begin
            // other frame types are handled but not taken
          end
        endcase
      end
    end
  end

endmodule

### rtl/isotp_rx_frame_classifier.sv
// ISO-TP receive frame classifier top level: input register, decode, result register.
// Depends on isotp_pkg, isotp_cfg_regs and isotp_decode.
//
// Usage:
//   Input channel: drive the in_* fields and pulse start; a word is taken at each
//   rising edge with start high and busy low. busy is always low, so one frame
//   can be taken every cycle.
//   Result channel: each result appears on the out_* ports for exactly one cycle
//   with out_valid high, once its frame has passed the input register and then
//   the result register, and is taken at the edge that ends that cycle. Results
//   leave in the order frames came in.
//   Throughput is one frame per cycle, set by the single decode stage between
//   the two registers.
//   Configuration: APB-style port, functional_rx_id at byte address 0 and
//   physical_rx_id at byte address 4; write only while no frame is in flight.
//   Reset (rst_n low, synchronous) clears both IDs and drops all words in flight.
//   The receiver cannot stall; it must take each result in its strobe cycle.
module isotp_rx_frame_classifier (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        start,
  output logic        busy,
  input  logic [28:0] in_can_id,
  input  logic [3:0]  in_frame_dlc,
  input  logic [7:0]  in_pci_byte,
  input  logic [7:0]  in_second_byte,
  input  logic [7:0]  in_third_byte,
  input  logic [2:0]  in_link_status,
  input  logic        in_module_on,
  // result channel
  output logic        out_valid,
  output logic [1:0]  out_verdict,
  output logic        out_functional_addr,
  output logic [2:0]  out_frame_kind,
  output logic [3:0]  out_single_length,
  output logic [11:0] out_first_length,
  output logic [3:0]  out_sequence_number,
  output logic [3:0]  out_flow_status,
  output logic [7:0]  out_block_size,
  output logic [7:0]  out_st_min,
  output logic [2:0]  out_next_link_status,
  output logic        out_wake_request,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import isotp_pkg::*;

  logic           in_acc;
  logic           s1_valid_r;
  frame_t         s1_frame_r;
  logic           out_valid_r;
  result_t        result_nxt;
  result_t        result_r;
  logic [IdW-1:0] func_id;
  logic [IdW-1:0] phys_id;

  assign busy   = 1'b0;
  assign in_acc = start & ~busy;

  isotp_cfg_regs u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .functional_rx_id (func_id),
    .physical_rx_id   (phys_id)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_frame_r.can_id      <= in_can_id;
      s1_frame_r.frame_dlc   <= in_frame_dlc;
      s1_frame_r.pci_byte    <= in_pci_byte;
      s1_frame_r.second_byte <= in_second_byte;
      s1_frame_r.third_byte  <= in_third_byte;
      s1_frame_r.link_status <= in_link_status;
      s1_frame_r.module_on   <= in_module_on;
    end
  end

  isotp_decode u_decode (
    .frame            (s1_frame_r),
    .functional_rx_id (func_id),
    .physical_rx_id   (phys_id),
    .result           (result_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_verdict          = result_r.verdict;
  assign out_functional_addr  = result_r.functional_addr;
  assign out_frame_kind       = result_r.frame_kind;
  assign out_single_length    = result_r.single_length;
  assign out_first_length     = result_r.first_length;
  assign out_sequence_number  = result_r.sequence_number;
  assign out_flow_status      = result_r.flow_status;
  assign out_block_size       = result_r.block_size;
  assign out_st_min           = result_r.st_min;
  assign out_next_link_status = result_r.next_link_status;
  assign out_wake_request     = result_r.wake_request;

`ifndef SYNTH
  // every result strobe comes from a frame taken by the input register and passed on by the result register
  a_out_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 2))
    else $error("result strobe without a frame taken two cycles earlier");

  // rejected frames (any verdict but handled) carry no decoded kind and no wake request
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict != VERDICT_HANDLED) |->
      (out_frame_kind == KIND_NONE && !out_wake_request))
    else $error("rejected frame carries decoded content");

  // flow control is only taken on physical addressing
  a_flow_physical: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_kind == KIND_FLOW) |-> !out_functional_addr)
    else $error("flow control taken on functional addressing");

  // only a taken single frame changes the link status
  a_link_change: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_next_link_status != $past(in_link_status, 2)) |->
      (out_frame_kind == KIND_SINGLE))
    else $error("link status changed without a single frame");
`endif

endmodule
